/* rtl/sdaq_pkg.sv */
// sdaq_pkg: shared types and constants of the sustained danger alarm qualifier
// holds the reading, result and configuration structs, alarm kind and register codes
// no dependencies
package sdaq_pkg;

  localparam int unsigned InDataW   = 88;  // 83 payload bits padded to whole bytes
  localparam int unsigned InUserW   = 4;
  localparam int unsigned OutDataW  = 24;  // 17 payload bits padded to whole bytes
  localparam int unsigned OutUserW  = 4;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned StreakW   = 8;
  localparam int unsigned ValueW    = 17;

  localparam logic [StreakW-1:0] StreakMax = '1;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_CO2     = 3'd1,
    KIND_NH3     = 3'd2,
    KIND_TEMP_HI = 3'd3,
    KIND_TEMP_LO = 3'd4,
    KIND_HUM_HI  = 3'd5,
    KIND_HUM_LO  = 3'd6
  } alarm_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CO2_LIMIT    = 3'd0,
    REG_NH3_LIMIT    = 3'd1,
    REG_TEMP_HIGH    = 3'd2,
    REG_TEMP_LOW     = 3'd3,
    REG_HUM_HIGH     = 3'd4,
    REG_HUM_LOW      = 3'd5,
    REG_CONFIRM      = 3'd6,
    REG_HOLDOFF      = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic               co2_valid;
    logic [15:0]        co2_ppm;
    logic               ammonia_valid;
    logic [12:0]        ammonia_tenths;
    logic               temp_valid;
    logic signed [11:0] temp_tenths;
    logic               hum_valid;
    logic [9:0]         hum_tenths;
    logic [31:0]        now_ms;
  } sample_t;

  typedef struct packed {
    logic [15:0]        co2_limit;
    logic [12:0]        ammonia_limit;
    logic signed [11:0] temp_high_limit;
    logic signed [11:0] temp_low_limit;
    logic [9:0]         hum_high_limit;
    logic [9:0]         hum_low_limit;
    logic [7:0]         confirm_count;
    logic [31:0]        refire_holdoff_ms;
  } cfg_t;

  typedef struct packed {
    logic                     fire;
    alarm_kind_e              kind;
    logic signed [ValueW-1:0] value;
  } result_t;

  localparam cfg_t CfgReset = '{
    co2_limit:         16'd3000,
    ammonia_limit:     13'd250,
    temp_high_limit:   12'sd350,
    temp_low_limit:    12'sd50,
    hum_high_limit:    10'd850,
    hum_low_limit:     10'd300,
    confirm_count:     8'd3,
    refire_holdoff_ms: 32'd1800000
  };

endpackage

/* rtl/sdaq_cfg_regs.sv */
// sdaq_cfg_regs: configuration register file of the alarm qualifier
// decodes register index writes into the cfg_t struct; depends on sdaq_pkg
module sdaq_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sdaq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sdaq_pkg::CfgDataW-1:0] cfg_data_i,
  output sdaq_pkg::cfg_t                cfg_o
);
  import sdaq_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CO2_LIMIT: cfg_d.co2_limit         = cfg_data_i[15:0];
        REG_NH3_LIMIT: cfg_d.ammonia_limit     = cfg_data_i[12:0];
        REG_TEMP_HIGH: cfg_d.temp_high_limit   = $signed(cfg_data_i[11:0]);
        REG_TEMP_LOW:  cfg_d.temp_low_limit    = $signed(cfg_data_i[11:0]);
        REG_HUM_HIGH:  cfg_d.hum_high_limit    = cfg_data_i[9:0];
        REG_HUM_LOW:   cfg_d.hum_low_limit     = cfg_data_i[9:0];
        REG_CONFIRM:   cfg_d.confirm_count     = cfg_data_i[7:0];
        REG_HOLDOFF:   cfg_d.refire_holdoff_ms = cfg_data_i[31:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/sdaq_core.sv */
// sdaq_core: streak counters, last fire time and the single-pass alarm decision
// evaluates one registered reading per step; depends on sdaq_pkg
module sdaq_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  sdaq_pkg::sample_t sample_i,
  input  sdaq_pkg::cfg_t    cfg_i,
  output sdaq_pkg::result_t result_o
);
  import sdaq_pkg::*;

  logic [StreakW-1:0] co2_streak_q, co2_streak_d;
  logic [StreakW-1:0] nh3_streak_q, nh3_streak_d;
  logic [StreakW-1:0] temp_streak_q, temp_streak_d;
  logic [StreakW-1:0] hum_streak_q, hum_streak_d;
  logic [31:0]        last_fire_q, last_fire_d;

  logic co2_danger, nh3_danger, temp_danger, hum_danger;
  logic temp_hi, temp_lo, hum_hi, hum_lo;
  logic co2_conf, nh3_conf, temp_conf, hum_conf;
  logic [31:0] elapsed;
  logic holdoff_ok;
  alarm_kind_e cand_kind;
  logic signed [ValueW-1:0] cand_value;

  function automatic logic [StreakW-1:0] next_streak(logic [StreakW-1:0] cur, logic danger);
    logic [StreakW-1:0] nxt;
    if (!danger) begin
      nxt = '0;
    end else if (cur == StreakMax) begin
      nxt = cur;
    end else begin
      nxt = cur + 1'b1;
    end
    return nxt;
  endfunction

  assign temp_hi = sample_i.temp_tenths >= cfg_i.temp_high_limit;
  assign temp_lo = sample_i.temp_tenths <= cfg_i.temp_low_limit;
  assign hum_hi  = sample_i.hum_tenths >= cfg_i.hum_high_limit;
  assign hum_lo  = sample_i.hum_tenths <= cfg_i.hum_low_limit;

  assign co2_danger  = sample_i.co2_valid && (sample_i.co2_ppm >= cfg_i.co2_limit);
  assign nh3_danger  = sample_i.ammonia_valid && (sample_i.ammonia_tenths >= cfg_i.ammonia_limit);
  assign temp_danger = sample_i.temp_valid && (temp_hi || temp_lo);
  assign hum_danger  = sample_i.hum_valid && (hum_hi || hum_lo);

  assign co2_streak_d  = next_streak(co2_streak_q, co2_danger);
  assign nh3_streak_d  = next_streak(nh3_streak_q, nh3_danger);
  assign temp_streak_d = next_streak(temp_streak_q, temp_danger);
  assign hum_streak_d  = next_streak(hum_streak_q, hum_danger);

  assign co2_conf  = co2_danger && (co2_streak_d >= cfg_i.confirm_count);
  assign nh3_conf  = nh3_danger && (nh3_streak_d >= cfg_i.confirm_count);
  assign temp_conf = temp_danger && (temp_streak_d >= cfg_i.confirm_count);
  assign hum_conf  = hum_danger && (hum_streak_d >= cfg_i.confirm_count);

  // later channel wins
  always_comb begin
    cand_kind  = KIND_NONE;
    cand_value = '0;
    if (hum_conf) begin
      cand_kind  = hum_hi ? KIND_HUM_HI : KIND_HUM_LO;
      cand_value = {7'b0, sample_i.hum_tenths};
    end else if (temp_conf) begin
      cand_kind  = temp_hi ? KIND_TEMP_HI : KIND_TEMP_LO;
      cand_value = {{5{sample_i.temp_tenths[11]}}, sample_i.temp_tenths};
    end else if (nh3_conf) begin
      cand_kind  = KIND_NH3;
      cand_value = {4'b0, sample_i.ammonia_tenths};
    end else if (co2_conf) begin
      cand_kind  = KIND_CO2;
      cand_value = {1'b0, sample_i.co2_ppm};
    end
  end

  // wrapped time since last fire
  assign elapsed    = sample_i.now_ms - last_fire_q;
  assign holdoff_ok = elapsed >= cfg_i.refire_holdoff_ms;

  always_comb begin
    result_o.fire  = 1'b0;
    result_o.kind  = KIND_NONE;
    result_o.value = '0;
    if ((cand_kind != KIND_NONE) && holdoff_ok) begin
      result_o.fire  = 1'b1;
      result_o.kind  = cand_kind;
      result_o.value = cand_value;
    end
  end

  assign last_fire_d = result_o.fire ? sample_i.now_ms : last_fire_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      co2_streak_q  <= '0;
      nh3_streak_q  <= '0;
      temp_streak_q <= '0;
      hum_streak_q  <= '0;
      last_fire_q   <= '0;
    end else if (step_i) begin
      co2_streak_q  <= co2_streak_d;
      nh3_streak_q  <= nh3_streak_d;
      temp_streak_q <= temp_streak_d;
      hum_streak_q  <= hum_streak_d;
      last_fire_q   <= last_fire_d;
    end
  end

`ifndef ASSERT_OFF
  a_fire_stamps_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.fire |=> last_fire_q == $past(sample_i.now_ms))
    else $error("last fire time not taken from fired reading");

  a_no_fire_keeps_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !result_o.fire |=> $stable(last_fire_q))
    else $error("last fire time moved without a fire");

  a_streak_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !hum_danger |=> hum_streak_q == '0)
    else $error("humidity streak not cleared on a safe reading");

  a_streak_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && co2_danger && co2_streak_q == StreakMax |=> co2_streak_q == StreakMax)
    else $error("co2 streak wrapped past saturation");

  a_fire_needs_holdoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.fire |-> (sample_i.now_ms - last_fire_q) >= cfg_i.refire_holdoff_ms)
    else $error("alarm fired inside the holdoff window");
`endif

endmodule

/* rtl/sustained_danger_alarm_qualifier_unit.sv */
// sustained_danger_alarm_qualifier_unit: top level, input and result registers
// instantiates sdaq_cfg_regs and sdaq_core; depends on sdaq_pkg
//
//   channel   dir  handshake               payload
//   s_axis    in   tvalid/tready           tdata: readings, tuser: presence flags
//   m_axis    out  tvalid/tready           tdata: alarm value, tuser: fire, kind
//   cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data (always ready)
//
// a reading passes through the input register, then the single-pass decision into the
// result register; one reading per cycle is sustained while m_axis_tready is high.
// streak and last-fire state update in the cycle a reading moves into the result register.
// reset clears streaks, last fire time and both valid flags; registers take defaults.
// a stalled result holds the input register, and input ready then follows m_axis_tready.
module sustained_danger_alarm_qualifier_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // co2_ppm[15:0], ammonia_tenths[28:16], temp_tenths[40:29], hum_tenths[50:41],
  // now_ms[82:51], zero fill above
  input  logic [sdaq_pkg::InDataW-1:0]  s_axis_tdata_i,
  // co2_valid[0], ammonia_valid[1], temp_valid[2], hum_valid[3]
  input  logic [sdaq_pkg::InUserW-1:0]  s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // alarm_value[16:0], zero fill above
  output logic [sdaq_pkg::OutDataW-1:0] m_axis_tdata_o,
  // alarm_fire[0], alarm_kind[3:1]
  output logic [sdaq_pkg::OutUserW-1:0] m_axis_tuser_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sdaq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sdaq_pkg::CfgDataW-1:0] cfg_data_i
);
  import sdaq_pkg::*;

  cfg_t    cfg;
  sample_t in_sample;
  sample_t s1_sample_q;
  logic    s1_valid_q, s1_valid_d;
  result_t core_res;
  result_t out_res_q;
  logic    out_valid_q, out_valid_d;
  logic    in_accept, advance, step;

  sdaq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  always_comb begin
    in_sample.co2_valid      = s_axis_tuser_i[0];
    in_sample.co2_ppm        = s_axis_tdata_i[15:0];
    in_sample.ammonia_valid  = s_axis_tuser_i[1];
    in_sample.ammonia_tenths = s_axis_tdata_i[28:16];
    in_sample.temp_valid     = s_axis_tuser_i[2];
    in_sample.temp_tenths    = $signed(s_axis_tdata_i[40:29]);
    in_sample.hum_valid      = s_axis_tuser_i[3];
    in_sample.hum_tenths     = s_axis_tdata_i[50:41];
    in_sample.now_ms         = s_axis_tdata_i[82:51];
  end

  // result register free or draining this cycle
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign step            = s1_valid_q && advance;
  assign s_axis_tready_o = !s1_valid_q || advance;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  sdaq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (s1_sample_q),
    .cfg_i    (cfg),
    .result_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sample_q <= in_sample;
    end
    if (step) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-ValueW){1'b0}}, out_res_q.value};
  assign m_axis_tuser_o  = {out_res_q.kind, out_res_q.fire};

endmodule
